@@ sv/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/stc_pkg.sv @@
package stc_pkg;

  typedef enum logic [1:0] {
    MODE_CALC  = 2'd0,
    MODE_WATCH = 2'd1,
    MODE_TIMER = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_PAUSE = 3'd1,
    KIND_RESET = 3'd2,
    KIND_MODE  = 3'd3,
    KIND_DIGIT = 3'd4,
    KIND_ENTER = 3'd5
  } kind_t;

  localparam int SEC_PER_MIN    = 60;
  localparam int MIN_PER_HOUR   = 60;
  localparam int HOUR_PER_DAY   = 24;
  localparam int SEC_MAX        = 59;
  localparam int SEC_TENS_LIMIT = 6;
  localparam int DIGIT_MAX      = 9;
  localparam int ENTRY_DEPTH    = 4;
  localparam int SEC_TENS_POS   = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] digit;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       paused;
    logic [4:0] hour_count;
    logic [6:0] minute_count;
    logic [5:0] second_count;
    logic       counting_down;
    logic       expired;
    logic       lamp_on;
    logic [2:0] entry_position;
  } out_item_t;

  // d * 10 as (d << 3) + (d << 1); a decimal digit times ten fits in 7 bits.
  function automatic logic [6:0] times_ten(input logic [3:0] d);
    times_ten = {d, 3'b000} + {2'b00, d, 1'b0};
  endfunction

endpackage

@@ sv/stc_in_reg.sv @@
module stc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stc_pkg::in_item_t in_item,
  input  logic              take,
  output logic              hold_valid,
  output stc_pkg::in_item_t hold_item
);

  // The held item may be replaced in the same cycle that it moves on.
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

@@ sv/stc_engine.sv @@
module stc_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  stc_pkg::in_item_t  item,
  output stc_pkg::out_item_t result
);

  stc_pkg::mode_t mode, mode_next;
  logic           paused, paused_next;
  logic [4:0]     hours, hours_next;
  logic [6:0]     minutes, minutes_next;
  logic [5:0]     seconds, seconds_next;
  logic [3:0]     digits [stc_pkg::ENTRY_DEPTH];
  logic [3:0]     digits_next [stc_pkg::ENTRY_DEPTH];
  logic [2:0]     entry_idx, entry_idx_next;
  logic           running, running_next;
  logic           lamp, lamp_next;
  logic           end_cd;

  logic [6:0] sec_up;
  logic [7:0] min_up;
  logic [5:0] hour_up;
  logic [6:0] cd_min;
  logic [5:0] cd_sec;
  logic [6:0] ent_min;
  logic [6:0] ent_sec_raw;
  logic [5:0] ent_sec;

  always_comb begin
    sec_up      = {1'b0, seconds} + 7'd1;
    min_up      = {1'b0, minutes} + 8'd1;
    hour_up     = {1'b0, hours} + 6'd1;
    // Countdown step: borrow a minute when the seconds are at zero.
    if (seconds == '0) begin
      cd_min = (minutes != '0) ? minutes - 7'd1 : minutes;
      cd_sec = (minutes != '0) ? 6'(stc_pkg::SEC_MAX) : seconds;
    end else begin
      cd_min = minutes;
      cd_sec = seconds - 6'd1;
    end
    ent_min     = stc_pkg::times_ten(digits[0]) + {3'b000, digits[1]};
    ent_sec_raw = stc_pkg::times_ten(digits[2]) + {3'b000, digits[3]};
    ent_sec     = (ent_sec_raw > 7'(stc_pkg::SEC_MAX)) ? 6'(stc_pkg::SEC_MAX)
                                                       : ent_sec_raw[5:0];
  end

  always_comb begin
    mode_next      = mode;
    paused_next    = paused;
    hours_next     = hours;
    minutes_next   = minutes;
    seconds_next   = seconds;
    digits_next    = digits;
    entry_idx_next = entry_idx;
    running_next   = running;
    lamp_next      = lamp;
    end_cd         = 1'b0;
    if (go) begin
      unique case (stc_pkg::kind_t'(item.kind))
        stc_pkg::KIND_TICK: begin
          if (mode == stc_pkg::MODE_WATCH && !paused) begin
            if (sec_up >= 7'(stc_pkg::SEC_PER_MIN)) begin
              seconds_next = '0;
              if (min_up >= 8'(stc_pkg::MIN_PER_HOUR)) begin
                minutes_next = '0;
                hours_next   = (hour_up >= 6'(stc_pkg::HOUR_PER_DAY)) ? '0 : hour_up[4:0];
              end else begin
                minutes_next = min_up[6:0];
              end
            end else begin
              seconds_next = sec_up[5:0];
            end
          end else if (mode == stc_pkg::MODE_TIMER && running && !paused) begin
            minutes_next = cd_min;
            seconds_next = cd_sec;
            end_cd       = (cd_min == '0) && (cd_sec == '0);
          end
        end
        stc_pkg::KIND_PAUSE: begin
          if (mode == stc_pkg::MODE_WATCH || mode == stc_pkg::MODE_TIMER) begin
            paused_next = !paused;
          end
        end
        stc_pkg::KIND_RESET: begin
          if (mode == stc_pkg::MODE_WATCH) begin
            hours_next   = '0;
            minutes_next = '0;
            seconds_next = '0;
          end else if (mode == stc_pkg::MODE_TIMER) begin
            minutes_next = '0;
            seconds_next = '0;
            lamp_next    = 1'b1;
            end_cd       = running;
          end
        end
        stc_pkg::KIND_MODE: begin
          if (mode == stc_pkg::MODE_WATCH) begin
            mode_next      = stc_pkg::MODE_TIMER;
            digits_next    = '{default: '0};
            entry_idx_next = '0;
          end else if (mode == stc_pkg::MODE_TIMER) begin
            mode_next    = stc_pkg::MODE_CALC;
            running_next = 1'b0;
          end else begin
            mode_next = stc_pkg::MODE_WATCH;
          end
        end
        stc_pkg::KIND_DIGIT: begin
          if (mode == stc_pkg::MODE_TIMER && !running
              && entry_idx < 3'(stc_pkg::ENTRY_DEPTH)
              && item.digit <= 4'(stc_pkg::DIGIT_MAX)
              && !(entry_idx == 3'(stc_pkg::SEC_TENS_POS)
                   && item.digit >= 4'(stc_pkg::SEC_TENS_LIMIT))) begin
            digits_next[entry_idx[1:0]] = item.digit;
            entry_idx_next              = entry_idx + 3'd1;
          end
        end
        stc_pkg::KIND_ENTER: begin
          if (mode == stc_pkg::MODE_TIMER && !running) begin
            minutes_next = ent_min;
            seconds_next = ent_sec;
            running_next = 1'b1;
            end_cd       = (ent_min == '0) && (ent_sec == '0);
          end
        end
        default: begin
        end
      endcase
      if (end_cd) begin
        running_next = 1'b0;
        lamp_next    = 1'b0;
        mode_next    = stc_pkg::MODE_CALC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= stc_pkg::MODE_CALC;
      paused    <= 1'b0;
      hours     <= '0;
      minutes   <= '0;
      seconds   <= '0;
      digits    <= '{default: '0};
      entry_idx <= '0;
      running   <= 1'b0;
      lamp      <= 1'b0;
    end else begin
      mode      <= mode_next;
      paused    <= paused_next;
      hours     <= hours_next;
      minutes   <= minutes_next;
      seconds   <= seconds_next;
      digits    <= digits_next;
      entry_idx <= entry_idx_next;
      running   <= running_next;
      lamp      <= lamp_next;
    end
  end

  always_comb begin
    result.mode           = mode_next;
    result.paused         = paused_next;
    result.hour_count     = hours_next;
    result.minute_count   = minutes_next;
    result.second_count   = seconds_next;
    result.counting_down  = running_next;
    result.expired        = end_cd;
    result.lamp_on        = lamp_next;
    result.entry_position = entry_idx_next;
  end

endmodule

@@ sv/stc_out_reg.sv @@
module stc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  stc_pkg::out_item_t result,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output stc_pkg::out_item_t out_item
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= result;
    end
  end

endmodule

@@ sv/stopwatch_countdown_timer.sv @@
// Stopwatch and countdown timer event block.
// Input channel (in_valid, in_ready, in_item) carries one event per item:
// a tick, a pause, reset or mode button, a digit key or the enter key.
// Output channel (out_valid, out_ready, out_item) returns exactly one result
// item per event, showing mode, time, flags and entry position after it.
// The event lands in an input register, and the next-state logic then
// updates the state and the result register together.
// Throughput is one item per cycle while out_ready stays high; the limit
// is the single state update per cycle that every event needs.
// When the receiver stalls, the result register holds its item and the
// input register holds one more, so in_ready drops only when both are full.
// Synchronous reset (rst high) puts the block in calculator mode with all
// counts, entry digits, flags and the lamp cleared, and empties both
// registers.
module stopwatch_countdown_timer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output stc_pkg::out_item_t out_item
);

  logic               hold_valid;
  stc_pkg::in_item_t  hold_item;
  logic               space;
  logic               advance;
  stc_pkg::out_item_t result;

  assign advance = hold_valid && space;

  stc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  stc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .item   (hold_item),
    .result (result)
  );

  stc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ sv/stc_checker.sv @@
`include "assert_macros.svh"

module stc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input stc_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input stc_pkg::out_item_t out_item
);

  `ASSERT_CLK(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_item),
    "result item dropped or changed while stalled")
  `ASSERT_CLK(a_in_to_out,
    in_valid && in_ready |-> ##2 out_valid,
    "accepted item gave no result within two cycles")
  `ASSERT_CLK(a_expire_calc,
    out_valid && out_item.expired |-> out_item.mode == stc_pkg::MODE_CALC
      && !out_item.counting_down && !out_item.lamp_on,
    "expiry without return to calculator mode")
  `ASSERT_CLK(a_run_timer,
    out_valid && out_item.counting_down |-> out_item.mode == stc_pkg::MODE_TIMER,
    "countdown running outside timer mode")
  `ASSERT_CLK(a_time_range,
    out_valid |-> out_item.hour_count < 5'd24 && out_item.second_count < 6'd60,
    "time field out of range")

endmodule

bind stopwatch_countdown_timer stc_checker u_stc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
